// File: hw/rtl/midi_byte_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// midi byte stream parser assertion macros
// shared property shorthands, sampled on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef MIDI_BYTE_STREAM_PARSER_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_DEFINES_SVH

// same-cycle implication
`define MBSP_ASSERT_NOW(lbl, ante, cons, txt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(txt);

// next-cycle implication
`define MBSP_ASSERT_NEXT(lbl, ante, cons, txt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(txt);

`endif

// File: hw/rtl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// types, status codes and lookup functions of the midi byte stream parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbsp_pkg;

    localparam logic [7:0] STATUS_BIT   = 8'h80;
    localparam logic [7:0] HIGH_NIB     = 8'hF0;
    localparam logic [7:0] LOW_NIB      = 8'h0F;
    localparam logic [7:0] RT_FIRST     = 8'hF8;

    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_POLY_AT   = 8'hA0;
    localparam logic [7:0] ST_CTRL      = 8'hB0;
    localparam logic [7:0] ST_PROG      = 8'hC0;
    localparam logic [7:0] ST_CHAN_AT   = 8'hD0;
    localparam logic [7:0] ST_BEND      = 8'hE0;
    localparam logic [7:0] ST_TIME_CODE = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;

    typedef struct packed {
        logic [7:0] status;
        logic [1:0] length;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic [4:0] channel;
    } msg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_stage_t;

    typedef struct packed {
        logic valid;
        msg_t msg;
    } result_t;

    // number of data bytes that follow a status byte
    function automatic logic [1:0] count_for(input logic [7:0] st);
        logic [7:0] hi;
        logic [1:0] cnt;
        hi = st & HIGH_NIB;
        case (hi) inside
            ST_PROG, ST_CHAN_AT:
                cnt = 2'd1;
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_BEND:
                cnt = 2'd2;
            default:
            begin
                case (st) inside
                    ST_TIME_CODE, ST_SONG_SEL: cnt = 2'd1;
                    ST_SONG_POS:               cnt = 2'd2;
                    default:                   cnt = 2'd0;
                endcase
            end
        endcase
        return cnt;
    endfunction

    // channel 1 to 16 for voice statuses, 0 for system
    function automatic logic [4:0] chan_of(input logic [7:0] st);
        logic [4:0] ch;
        if ((st & HIGH_NIB) < HIGH_NIB)
        begin
            ch = 5'({1'b0, st[3:0]}) + 5'd1;
        end
        else
        begin
            ch = 5'd0;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mbsp_channels.sv
// ----------------------------------------------------------------------------
// mbsp channels
// valid/ready interfaces for the raw byte stream and the decoded messages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface mbsp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_status;
    logic [1:0] msg_length;
    logic [6:0] msg_data_first;
    logic [6:0] msg_data_second;
    logic [4:0] msg_channel;

    modport source (output valid, output msg_status, output msg_length,
                    output msg_data_first, output msg_data_second,
                    output msg_channel, input ready);
    modport sink   (input valid, input msg_status, input msg_length,
                    input msg_data_first, input msg_data_second,
                    input msg_channel, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mbsp_in_stage.sv
// ----------------------------------------------------------------------------
// mbsp_in_stage
// input register for one midi byte, refilled in the cycle it is consumed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbsp_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    mbsp_byte_if.sink                 midi,
    input  wire logic                 fire,
    output mbsp_pkg::byte_stage_t     stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // empty or draining this cycle
    assign midi.ready = !valid_reg || fire;

    always_comb
    begin
        valid_next = valid_reg;
        if (midi.ready)
        begin
            valid_next = midi.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (midi.valid && midi.ready)
        begin
            byte_reg <= midi.in_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = byte_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mbsp_core.sv
// ----------------------------------------------------------------------------
// mbsp_core
// running status state and per-byte message decode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "midi_byte_stream_parser_defines.svh"

module mbsp_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mbsp_pkg::byte_stage_t stage,
    input  wire logic                 fire,
    output mbsp_pkg::result_t         res
);

    logic [7:0] status_reg;
    logic [7:0] status_next;
    logic       pos_reg;
    logic       pos_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [6:0] slot0_reg;
    logic [6:0] slot0_next;
    logic [6:0] slot1_reg;
    logic [6:0] slot1_next;

    logic [7:0] b;
    logic       is_rt;
    logic       is_status;
    logic [1:0] new_cnt;
    logic [1:0] filled;

    assign b         = stage.data;
    assign is_rt     = b >= mbsp_pkg::RT_FIRST;
    assign is_status = (b & mbsp_pkg::STATUS_BIT) != 8'h00;
    assign new_cnt   = mbsp_pkg::count_for(b);
    assign filled    = 2'({1'b0, pos_reg}) + 2'd1;

    always_comb
    begin
        status_next = status_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        slot0_next  = slot0_reg;
        slot1_next  = slot1_reg;
        res         = '0;

        if (is_rt)
        begin
            // realtime, state untouched, zeroed data
            res.valid          = 1'b1;
            res.msg.status     = b;
            res.msg.length     = 2'd0;
            res.msg.channel    = mbsp_pkg::chan_of(b);
        end
        else if (is_status)
        begin
            status_next = b;
            pos_next    = 1'b0;
            cnt_next    = new_cnt;
            if (new_cnt == 2'd0)
            begin
                res.valid           = 1'b1;
                res.msg.status      = b;
                res.msg.length      = 2'd0;
                res.msg.data_first  = slot0_reg;
                res.msg.data_second = slot1_reg;
                res.msg.channel     = mbsp_pkg::chan_of(b);
            end
        end
        else if (status_reg != 8'h00)
        begin
            if (pos_reg)
            begin
                slot1_next = b[6:0];
            end
            else
            begin
                slot0_next = b[6:0];
            end
            if (filled >= cnt_reg)
            begin
                pos_next            = 1'b0;
                res.valid           = 1'b1;
                res.msg.status      = status_reg;
                res.msg.length      = cnt_reg;
                res.msg.data_first  = slot0_next;
                res.msg.data_second = slot1_next;
                res.msg.channel     = mbsp_pkg::chan_of(status_reg);
            end
            else
            begin
                pos_next = 1'b1;
            end
        end

        if (!stage.valid)
        begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'h00;
            pos_reg    <= 1'b0;
            cnt_reg    <= 2'd0;
            slot0_reg  <= 7'd0;
            slot1_reg  <= 7'd0;
        end
        else if (fire)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            slot0_reg  <= slot0_next;
            slot1_reg  <= slot1_next;
        end
    end

    `MBSP_ASSERT_NEXT(a_rt_keeps_state, fire && is_rt,
        $stable(status_reg) && $stable(pos_reg) && $stable(cnt_reg),
        "realtime byte changed parser state")
    `MBSP_ASSERT_NOW(a_pos_needs_two, pos_reg, cnt_reg == 2'd2,
        "half-filled message under a count other than two")
    `MBSP_ASSERT_NOW(a_pos_needs_status, status_reg == 8'h00, !pos_reg,
        "data slot filled before any status")
    `MBSP_ASSERT_NOW(a_res_is_status, res.valid, res.msg.status[7],
        "message without a status byte")

endmodule

`default_nettype wire

// File: hw/rtl/mbsp_out_stage.sv
// ----------------------------------------------------------------------------
// mbsp_out_stage
// result register driving the message channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbsp_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire mbsp_pkg::result_t    res,
    output logic                      space,
    mbsp_msg_if.source                msg
);

    logic           valid_reg;
    logic           valid_next;
    mbsp_pkg::msg_t msg_reg;

    // register free or emptied by this cycle's transfer
    assign space = !valid_reg || msg.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = res.valid;
        end
        else if (msg.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            msg_reg <= res.msg;
        end
    end

    assign msg.valid           = valid_reg;
    assign msg.msg_status      = msg_reg.status;
    assign msg.msg_length      = msg_reg.length;
    assign msg.msg_data_first  = msg_reg.data_first;
    assign msg.msg_data_second = msg_reg.data_second;
    assign msg.msg_channel     = msg_reg.channel;

endmodule

`default_nettype wire

// File: hw/rtl/midi_byte_stream_parser.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser
// running status midi parser, one raw byte in, at most one message out
// ----------------------------------------------------------------------------
// Takes one byte of a MIDI stream per transfer on midi and hands out a
// message on msg each time one completes. The block accepts a byte in every
// cycle when msg keeps up; a byte is held in the input register, decoded,
// and the message is loaded into the result register, which drives msg.
// Realtime bytes (0xF8 and up) pass straight through with length 0, zero
// data and no effect on the running status. Other status bytes set the
// running status and the expected data count; statuses with no data
// bytes complete at once. Data bytes before any status are dropped. Unused
// data fields carry whatever the slots last held. Channel is 1 to 16 for
// voice messages and 0 for system messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_byte_stream_parser (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mbsp_byte_if.sink   midi,
    mbsp_msg_if.source  msg
);

    // byte held in the input register
    mbsp_pkg::byte_stage_t stage;
    // decode of that byte against the current state
    mbsp_pkg::result_t     res;
    // result register can take a new value
    logic                  space;
    // the held byte is consumed: state updates and the result is loaded
    logic                  fire;

    assign fire = stage.valid && space;

    // input register
    mbsp_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .midi  (midi),
        .fire  (fire),
        .stage (stage)
    );

    // running status, data slots and message decode
    mbsp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .fire  (fire),
        .res   (res)
    );

    // result register, bytes that complete no message leave it untouched
    mbsp_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .res   (res),
        .space (space),
        .msg   (msg)
    );

endmodule

`default_nettype wire
